/* src/stns_pkg.sv */
`timescale 1ns / 1ps
package stns_pkg;
	localparam int DEPTH    = 256;
	localparam int KEY_BITS = 32;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int FUNC_W   = 2;
	localparam int POS_W    = 8;
	localparam int KEY_IN_W = 32;
	localparam int CNT_W    = 9;
	localparam int INDEX_W  = 8;
	localparam int EXT_W    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

	localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(256);
	localparam logic [FUNC_W-1:0] FN_LOAD    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_NEAREST = 2'd1;

	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_LAST,
		ST_RD_FIRST,
		ST_BISECT,
		ST_NEAR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic take_last;
		logic take_first;
		logic step;
		logic near;
		logic finish;
		logic miss;
	} cmd_t;

	typedef struct packed {
		logic out_of_range;
		logic more;
	} status_t;

	function automatic key_t fit_key(input logic signed [KEY_IN_W-1:0] k);
		logic signed [63:0] w;
		w = 64'(k);
		return key_t'(w[KEY_BITS-1:0]);
	endfunction
endpackage

/* src/stns_if.sv */
`timescale 1ns / 1ps
interface stns_in_if;
	logic                                valid;
	logic                                ready;
	logic [stns_pkg::FUNC_W-1:0]         func;
	logic [stns_pkg::POS_W-1:0]          position;
	logic signed [stns_pkg::KEY_IN_W-1:0] key;

	modport source(output valid, func, position, key, input ready);
	modport sink(input valid, func, position, key, output ready);
endinterface

interface stns_out_if;
	logic                         valid;
	logic                         ready;
	logic                         in_range;
	logic [stns_pkg::INDEX_W-1:0] index;

	modport source(output valid, in_range, index, input ready);
	modport sink(input valid, in_range, index, output ready);
endinterface

/* src/stns_ram.sv */
`timescale 1ns / 1ps
module stns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/stns_ctrl.sv */
`timescale 1ns / 1ps
module stns_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic [stns_pkg::FUNC_W-1:0] func,
	input  logic                        result_ready,
	input  stns_pkg::status_t           status,
	output stns_pkg::cmd_t              cmd,
	output logic                        item_ready,
	output logic                        result_valid
);
	import stns_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign item_ready   = (state_q == ST_IDLE) && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load || cmd.miss || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && item_ready) begin
					if (func == FN_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_RD_LAST;
					end
				end
			end
			ST_RD_LAST: begin
				cmd.take_last = 1'b1;
				state_d       = ST_RD_FIRST;
			end
			ST_RD_FIRST: begin
				cmd.take_first = 1'b1;
				priority if (status.out_of_range) begin
					cmd.miss = 1'b1;
					state_d  = ST_IDLE;
				end else if (status.more) begin
					state_d = ST_BISECT;
				end else begin
					state_d = ST_NEAR;
				end
			end
			ST_BISECT: begin
				cmd.step = 1'b1;
				if (!status.more) begin
					state_d = ST_NEAR;
				end
			end
			ST_NEAR: begin
				cmd.near = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

/* src/stns_dp.sv */
`timescale 1ns / 1ps
module stns_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [stns_pkg::CNT_W-1:0]           cfg_wdata,
	input  logic [stns_pkg::FUNC_W-1:0]          func,
	input  logic [stns_pkg::POS_W-1:0]           position,
	input  logic signed [stns_pkg::KEY_IN_W-1:0] key,
	input  stns_pkg::cmd_t                       cmd,
	output stns_pkg::status_t                    status,
	output logic                                 in_range,
	output logic [stns_pkg::INDEX_W-1:0]         index
);
	import stns_pkg::*;

	logic [CNT_W-1:0]       entry_count_q;
	logic [EXT_W-1:0]       cnt_ext, pos_ext, res_ext;
	logic [FUNC_W-1:0]      func_q;
	key_t                   key_q, vl_q, vr_q, rdata, wkey;
	logic signed [KEY_BITS:0] d1_q, d2_q;
	idx_t                   left_q, right_q, mid_q, nl, nr, rd_addr, last_idx;
	logic [IDX_W:0]         sum, span;
	logic                   above_mid, wr_en, closer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CNT_RESET;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	assign cnt_ext = EXT_W'(entry_count_q);

	always_comb begin
		priority if (cnt_ext == '0) begin
			last_idx = '0;
		end else if (cnt_ext > EXT_W'(DEPTH)) begin
			last_idx = IDX_W'(DEPTH - 1);
		end else begin
			last_idx = IDX_W'(cnt_ext - EXT_W'(1));
		end
	end

	assign wkey    = fit_key(key);
	assign pos_ext = EXT_W'(position);
	assign wr_en   = cmd.load && (pos_ext < EXT_W'(DEPTH));

	stns_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(pos_ext[IDX_W-1:0]),
		.wdata(wkey),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign above_mid = key_q > rdata;

	always_comb begin
		nl = left_q;
		nr = right_q;
		if (cmd.step) begin
			if (above_mid) begin
				nl = mid_q;
			end else begin
				nr = mid_q;
			end
		end
	end

	assign span = {1'b0, nr} - {1'b0, nl};
	assign sum  = {1'b0, nl} + {1'b0, nr};

	always_comb begin
		priority if (cmd.start) begin
			rd_addr = last_idx;
		end else if (cmd.take_last) begin
			rd_addr = '0;
		end else begin
			rd_addr = sum[IDX_W:1];
		end
	end

	assign status.more         = span > (IDX_W + 1)'(1);
	assign status.out_of_range = (key_q > vr_q) || (key_q < rdata);

	always_ff @(posedge clk) begin
		mid_q <= rd_addr;
		if (cmd.start) begin
			key_q   <= wkey;
			func_q  <= func;
			left_q  <= '0;
			right_q <= last_idx;
		end
		if (cmd.take_last) begin
			vr_q <= rdata;
		end
		if (cmd.take_first) begin
			vl_q <= rdata;
		end
		if (cmd.step) begin
			left_q  <= nl;
			right_q <= nr;
			if (above_mid) begin
				vl_q <= rdata;
			end else begin
				vr_q <= rdata;
			end
		end
		if (cmd.near) begin
			d1_q <= {vr_q[KEY_BITS-1], vr_q} - {key_q[KEY_BITS-1], key_q};
			d2_q <= {key_q[KEY_BITS-1], key_q} - {vl_q[KEY_BITS-1], vl_q};
		end
	end

	// sign mismatch decides; equal signs reduce to a signed compare
	assign closer  = (d1_q[KEY_BITS] != d2_q[KEY_BITS]) ? d1_q[KEY_BITS] : (d1_q < d2_q);
	assign res_ext = EXT_W'(((func_q == FN_NEAREST) && closer) ? right_q : left_q);

	always_ff @(posedge clk) begin
		priority if (cmd.load) begin
			in_range <= 1'b1;
			index    <= position;
		end else if (cmd.miss) begin
			in_range <= 1'b0;
			index    <= '0;
		end else if (cmd.finish) begin
			in_range <= 1'b1;
			index    <= res_ext[INDEX_W-1:0];
		end
	end
endmodule

/* src/sorted_table_nearest_search.sv */
// Load transaction: result valid in the cycle after acceptance, next transaction then.
// Search: states RD_LAST, RD_FIRST, BISECT while the span exceeds one, NEAR and FINISH,
// then the result; one bisection step per table RAM read. Out of range: result after RD_FIRST.
// One search in flight; a new transaction can be accepted at the edge that takes the result.
// Reset: entry_count returns to 256; table contents are kept undefined, no clearing pass.
`timescale 1ns / 1ps
module sorted_table_nearest_search (
	input  logic                       clk,
	input  logic                       arst_n,
	stns_in_if.sink                    item,
	stns_out_if.source                 result,
	input  logic                       cfg_we,
	input  logic [stns_pkg::CNT_W-1:0] cfg_wdata
);
	import stns_pkg::*;

	cmd_t    cmd;
	status_t status;

	stns_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.func        (item.func),
		.result_ready(result.ready),
		.status      (status),
		.cmd         (cmd),
		.item_ready  (item.ready),
		.result_valid(result.valid)
	);

	stns_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.func     (item.func),
		.position (item.position),
		.key      (item.key),
		.cmd      (cmd),
		.status   (status),
		.in_range (result.in_range),
		.index    (result.index)
	);
endmodule

/* verif/sorted_table_nearest_search_test.sv */
`timescale 1ns / 1ps
module sorted_table_nearest_search_test;
	import stns_pkg::*;

	localparam logic [FUNC_W-1:0] FN_LEFT  = 2'd2;
	localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
	localparam longint KMIN        = -64'sd2147483648;
	localparam longint KMAX        = 64'sd2147483647;
	localparam int     IDLE_PCT    = 37;
	localparam int     QUIET_LIMIT = 3000;
	localparam int     TAIL_CYCLES = 40;

	typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_t;

	typedef struct {
		op_t               op;
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  position;
		key_t              key;
		logic [CNT_W-1:0]  count;
		logic              calm;
	} job_t;

	typedef struct packed {
		logic               in_range;
		logic [INDEX_W-1:0] index;
	} answer_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	stns_in_if  item_if();
	stns_out_if result_if();

	sorted_table_nearest_search u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_if),
		.result   (result_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	job_t    plan[$];
	answer_t answers_due[$];

	// generator shadow of the table, known at planning time
	key_t gen_tab [DEPTH];
	int   gen_n = 1;

	// predictor state, tracked at the accepting edges
	key_t             key_mem [DEPTH];
	logic [CNT_W-1:0] count_reg;

	int   sent_cnt;
	int   got_cnt;
	int   quiet_cycles;
	int   mismatches;
	int   n_load, n_near, n_left, n_off;
	logic calm_now;
	logic took, busy, go, wr;
	job_t job;
	answer_t want;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns  MISMATCH  %s", $time, msg);
		mismatches++;
	endtask

	function automatic int span_of(input logic [CNT_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > DEPTH)
			return DEPTH;
		return int'(c);
	endfunction

	function automatic answer_t nearest_lookup(input logic [FUNC_W-1:0] fn, input key_t x,
			input int n);
		answer_t r;
		int lo, hi, mid;
		r.in_range = 1'b0;
		r.index    = '0;
		if (x < key_mem[0] || x > key_mem[n-1])
			return r;
		lo = 0;
		hi = n - 1;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (x > key_mem[mid])
				lo = mid;
			else
				hi = mid;
		end
		r.in_range = 1'b1;
		r.index    = INDEX_W'(lo);
		// exact signed distances; a tie stays on the left
		if (fn == FN_NEAREST &&
				longint'(key_mem[hi]) - longint'(x) < longint'(x) - longint'(key_mem[lo]))
			r.index = INDEX_W'(hi);
		return r;
	endfunction

	task automatic put_item(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
			input key_t k, input logic calm);
		job_t j;
		j.op       = OP_ITEM;
		j.func     = fn;
		j.position = pos;
		j.key      = k;
		j.count    = '0;
		j.calm     = calm;
		plan.push_back(j);
		if (fn == FN_LOAD)
			gen_tab[pos] = k;
	endtask

	task automatic put_ctrl(input op_t op, input logic [CNT_W-1:0] cnt);
		job_t j;
		j.op       = op;
		j.func     = FN_LOAD;
		j.position = '0;
		j.key      = '0;
		j.count    = cnt;
		j.calm     = 1'b0;
		plan.push_back(j);
		if (op == OP_CFG)
			gen_n = span_of(cnt);
	endtask

	task automatic fill_table(input int n);
		longint v, stepmax;
		int mode, i;
		mode = $urandom_range(0, 3);
		case (mode)
			0: begin
				v = KMIN;
				stepmax = (KMAX - KMIN) / n * 2;
			end
			1: begin
				v = longint'($urandom_range(0, 2**21)) - 2**20;
				stepmax = 3;
			end
			2: begin
				v = longint'(key_t'($urandom));
				stepmax = (KMAX - v) / n;
			end
			default: begin
				v = longint'($urandom_range(0, 2**24)) - 2**23;
				stepmax = 65536;
			end
		endcase
		for (i = 0; i < n; i++) begin
			if (mode == 0 && n > 1 && i == n - 1)
				v = KMAX;
			put_item(FN_LOAD, POS_W'(i), key_t'(v), 1'b0);
			v = v + longint'($urandom) % (stepmax + 1);
			if (v > KMAX)
				v = KMAX;
		end
	endtask

	function automatic key_t probe_key();
		int r;
		longint a, b, k;
		r = $urandom_range(0, gen_n - 1);
		a = gen_tab[r];
		b = (r + 1 < gen_n) ? longint'(gen_tab[r+1]) : a;
		case ($urandom_range(0, 9))
			0, 9: k = a;
			1: k = a + longint'($urandom % 7) - 3;
			2, 3: k = ((a + b) >>> 1) + longint'($urandom_range(0, 1));
			4: k = (b >= a) ? a + longint'($urandom) % (b - a + 1) : a;
			5: k = longint'(gen_tab[0]) - longint'($urandom_range(1, 1000));
			6: k = longint'(gen_tab[gen_n-1]) + longint'($urandom_range(1, 1000));
			7: k = longint'(key_t'($urandom));
			default: k = $urandom_range(0, 1) ? KMIN : KMAX;
		endcase
		if (k < KMIN)
			k = KMIN;
		if (k > KMAX)
			k = KMAX;
		return key_t'(k);
	endfunction

	task automatic run_phase(input logic [CNT_W-1:0] cnt, input bit refill, input int items,
			input logic calm);
		int i, pick;
		put_ctrl(OP_CFG, cnt);
		if (refill)
			fill_table(gen_n);
		for (i = 0; i < items; i++) begin
			if (i == items / 2)
				put_ctrl(OP_DRAIN, '0);
			pick = $urandom_range(0, 99);
			if (pick < 4)
				put_item(FN_LOAD, POS_W'($urandom), key_t'($urandom), calm);
			else if (pick < 12)
				put_item(FN_LOAD, POS_W'($urandom_range(0, gen_n - 1)), probe_key(), calm);
			else if (pick < 55)
				put_item(FN_NEAREST, POS_W'($urandom), probe_key(), calm);
			else if (pick < 94)
				put_item(FN_LEFT, POS_W'($urandom), probe_key(), calm);
			else
				put_item(FN_SPARE, POS_W'($urandom), probe_key(), calm);
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid    <= 1'b0;
			item_if.func     <= FN_LOAD;
			item_if.position <= '0;
			item_if.key      <= '0;
			cfg_we           <= 1'b0;
			cfg_wdata        <= '0;
			sent_cnt         <= 0;
			calm_now         <= 1'b0;
		end else begin
			took = item_if.valid && item_if.ready;
			busy = item_if.valid && !took;
			go   = 1'b0;
			wr   = 1'b0;
			if (!busy && plan.size() != 0) begin
				job = plan[0];
				if (job.op == OP_ITEM) begin
					go = job.calm || ($urandom_range(0, 99) >= IDLE_PCT);
					if (go)
						void'(plan.pop_front());
				end else if (!took && sent_cnt == got_cnt) begin
					wr = (job.op == OP_CFG);
					void'(plan.pop_front());
				end
			end
			if (took)
				sent_cnt <= sent_cnt + 1;
			item_if.valid <= busy || go;
			if (go) begin
				item_if.func     <= job.func;
				item_if.position <= job.position;
				item_if.key      <= job.key;
				calm_now         <= job.calm;
			end
			cfg_we <= wr;
			if (wr)
				cfg_wdata <= job.count;
		end
	end

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_if.ready <= 1'b0;
		else
			result_if.ready <= calm_now || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// monitor and predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_cnt   <= 0;
			count_reg = CNT_RESET;
		end else begin
			if (cfg_we)
				count_reg = cfg_wdata;
			if (result_if.valid && result_if.ready) begin
				got_cnt <= got_cnt + 1;
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result in_range=%0b index=%0d",
						result_if.in_range, result_if.index));
				end else begin
					want = answers_due.pop_front();
					if (result_if.in_range !== want.in_range)
						report_mismatch($sformatf("in_range got %0b want %0b",
							result_if.in_range, want.in_range));
					if (result_if.index !== want.index)
						report_mismatch($sformatf("index got %0d want %0d",
							result_if.index, want.index));
				end
			end
			if (item_if.valid && item_if.ready) begin
				if (item_if.func == FN_LOAD) begin
					key_mem[item_if.position] = item_if.key;
					want.in_range = 1'b1;
					want.index    = item_if.position;
					n_load++;
				end else begin
					want = nearest_lookup(item_if.func, item_if.key, span_of(count_reg));
					if (item_if.func == FN_NEAREST)
						n_near++;
					else
						n_left++;
					if (!want.in_range)
						n_off++;
				end
				answers_due.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_if.valid && item_if.ready) ||
				(result_if.valid && result_if.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: %0d cycles without a transaction", quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;

		// single entry, then a two-entry table at the key extremes, then a tie
		put_ctrl(OP_CFG, 9'd1);
		put_item(FN_LOAD, 8'd0, key_t'(32'sh0005_0000), 1'b0);
		put_item(FN_NEAREST, 8'hFF, key_t'(32'sh0005_0000), 1'b0);
		put_item(FN_LEFT, 8'h00, key_t'(32'sh0005_0000), 1'b0);
		put_item(FN_SPARE, 8'h5A, key_t'(32'sh0004_FFFF), 1'b0);
		put_item(FN_NEAREST, 8'hA5, key_t'(32'sh0005_0001), 1'b0);
		put_item(FN_LOAD, 8'd255, key_t'(KMAX), 1'b0);
		put_item(FN_LOAD, 8'd1, key_t'(KMAX), 1'b0);
		put_item(FN_LOAD, 8'd0, key_t'(KMIN), 1'b0);
		put_ctrl(OP_CFG, 9'd2);
		put_item(FN_NEAREST, 8'h00, key_t'(KMIN), 1'b0);
		put_item(FN_NEAREST, 8'hFF, key_t'(KMAX), 1'b0);
		put_item(FN_NEAREST, 8'h0F, key_t'(32'sd0), 1'b0);
		put_item(FN_NEAREST, 8'hF0, key_t'(-32'sd1), 1'b0);
		put_item(FN_LEFT, 8'h33, key_t'(32'sd0), 1'b0);
		put_item(FN_SPARE, 8'hCC, key_t'(KMAX), 1'b0);
		put_item(FN_LOAD, 8'd0, key_t'(32'sd0), 1'b0);
		put_item(FN_LOAD, 8'd1, key_t'(32'sd10), 1'b0);
		put_item(FN_NEAREST, 8'h01, key_t'(32'sd5), 1'b0);
		put_item(FN_NEAREST, 8'h02, key_t'(32'sd6), 1'b0);
		put_item(FN_LEFT, 8'h04, key_t'(32'sd9), 1'b0);

		run_phase(9'd256, 1, 80, 1'b0);
		run_phase(9'd2, 1, 60, 1'b0);
		run_phase(9'd3, 1, 60, 1'b0);
		run_phase(9'd1, 1, 40, 1'b0);
		run_phase(9'd17, 1, 90, 1'b1);
		run_phase(9'd255, 1, 80, 1'b0);
		run_phase(9'd0, 0, 40, 1'b0);
		run_phase(9'd511, 0, 60, 1'b0);
		run_phase(CNT_W'($urandom_range(4, 64)), 1, 90, 1'b0);
		run_phase(CNT_W'($urandom_range(4, 64)), 1, 90, 1'b0);
		run_phase(9'd256, 0, 90, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (plan.size() != 0 || item_if.valid || got_cnt != sent_cnt)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (answers_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", answers_due.size()));

		$display("Covered %0d table writes and %0d searches (%0d nearest, %0d left, %0d off-table)",
			n_load, n_near + n_left, n_near, n_left, n_off);
		$display("Entry counts 0 to 511 exercised, %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

/* filelist.f */
src/stns_pkg.sv
src/stns_if.sv
src/stns_ram.sv
src/stns_ctrl.sv
src/stns_dp.sv
src/sorted_table_nearest_search.sv
verif/sorted_table_nearest_search_test.sv
